// ----- src/bm3_pkg.sv -----
// Shared types and constants for the 3x3 binary morphology filter.
package bm3_pkg;

   localparam int PIX_W = 8;
   localparam int WIN = 5;
   localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
   localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

   typedef enum logic [1:0] {
      MODE_ERODE  = 2'd0,
      MODE_DILATE = 2'd1,
      MODE_OPEN   = 2'd2,
      MODE_CLOSE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE   = 2'd0,
      REG_MASK   = 2'd1,
      REG_WIDTH  = 2'd2,
      REG_HEIGHT = 2'd3
   } reg_type;

   typedef logic [WIN-1:0][PIX_W-1:0] column_type;
   typedef column_type [WIN-1:0] window_type;

   typedef struct packed {
      logic           res;
      logic           eof;
      mode_type       mode;
      logic [8:0]     mask;
      logic [WIN-1:0] rv;
      logic [WIN-1:0] cv;
   } ctrl_type;

endpackage

// ----- src/bm3_linebuf.sv -----
// Four-line pixel history that yields one five-row column per word.
module bm3_linebuf #(
   parameter int DEPTH = 1024,
   parameter int AW = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [AW-1:0]       addr,
   input  logic [7:0]          pixel,
   output bm3_pkg::column_type col
);
   import bm3_pkg::*;

   logic [4*PIX_W-1:0] mem [DEPTH];
   logic [4*PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [AW-1:0]      addr_ff;
   logic               wb_ff;
   logic [4*PIX_W-1:0] wdata;

   assign wdata = {rd_ff[3*PIX_W-1:0], pix_ff};

   always_ff @(posedge clock) begin
      if (wb_ff) begin
         mem[addr_ff] <= wdata;
      end
      if (load) begin
         if (wb_ff && addr_ff == addr) begin
            rd_ff <= wdata;
         end else begin
            rd_ff <= mem[addr];
         end
         pix_ff  <= pixel;
         addr_ff <= addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff <= 1'b0;
      end else if (load) begin
         wb_ff <= 1'b1;
      end
   end

   assign col[0] = pix_ff;
   assign col[1] = rd_ff[PIX_W-1:0];
   assign col[2] = rd_ff[2*PIX_W-1:PIX_W];
   assign col[3] = rd_ff[3*PIX_W-1:2*PIX_W];
   assign col[4] = rd_ff[4*PIX_W-1:3*PIX_W];

endmodule

// ----- src/bm3_cell.sv -----
// One window column cell that passes its column to the next cell on each shift.
module bm3_cell (
   input  logic                clock,
   input  logic                shift,
   input  bm3_pkg::column_type col_in,
   output bm3_pkg::column_type col_out
);
   import bm3_pkg::*;

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

// ----- src/bm3_kernel.sv -----
// Two-level 3x3 erosion and dilation over the 5x5 pixel window.
module bm3_kernel (
   input  bm3_pkg::window_type win,
   input  bm3_pkg::ctrl_type   ctrl,
   output logic [7:0]          result_pixel,
   output logic                changed
);
   import bm3_pkg::*;

   logic [2:0][2:0] ero_w;
   logic [2:0][2:0] dil_w;
   logic            res;

   always_comb begin
      int yc;
      int xc;
      int ey;
      int ex;
      int y;
      int x;
      logic fe;
      logic fd;
      logic fo;
      logic fc;
      for (yc = 1; yc <= 3; yc++) begin
         for (xc = 1; xc <= 3; xc++) begin
            fe = 1'b0;
            fd = 1'b0;
            for (ey = 0; ey < 3; ey++) begin
               for (ex = 0; ex < 3; ex++) begin
                  y = yc + ey - 1;
                  x = xc + ex - 1;
                  if (ctrl.mask[ey*3+ex] && ctrl.rv[y] && ctrl.cv[x]) begin
                     if (win[4-x][4-y] == PIX_WHITE) begin
                        fe = 1'b1;
                     end
                     if (win[4-x][4-y] == PIX_BLACK) begin
                        fd = 1'b1;
                     end
                  end
               end
            end
            ero_w[yc-1][xc-1] = fe;
            dil_w[yc-1][xc-1] = !fd;
         end
      end
      fo = 1'b0;
      fc = 1'b0;
      for (y = 1; y <= 3; y++) begin
         for (x = 1; x <= 3; x++) begin
            if (ctrl.mask[(y-1)*3+(x-1)] && ctrl.rv[y] && ctrl.cv[x]) begin
               if (!ero_w[y-1][x-1]) begin
                  fo = 1'b1;
               end
               if (dil_w[y-1][x-1]) begin
                  fc = 1'b1;
               end
            end
         end
      end
      case (ctrl.mode)
         MODE_ERODE:  res = ero_w[1][1];
         MODE_DILATE: res = dil_w[1][1];
         MODE_OPEN:   res = !fo;
         default:     res = fc;
      endcase
   end

   assign result_pixel = res ? PIX_WHITE : PIX_BLACK;
   assign changed = (result_pixel != win[2][2]);

endmodule

// ----- src/binary_morphology_3x3.sv -----
// Top level of the streaming 3x3 binary morphology filter.
//
//   port group | direction | words
//   req_*      | in        | pixel_value, is_padding
//   rsp_*      | out       | result_pixel, changed, end_of_frame
//   csr_*      | in/out    | mode, kernel_mask, image_width, image_height
//
// A word is taken per cycle while req_ready is high; a result passes stages A, B and the output
// register after the word that releases it, which is the word 2*W+2 raster places later.
// Reset is synchronous and clears counters, valid flags and the registers to their defaults.
// A stalled result holds the output register; the two stages behind it still fill.
module binary_morphology_3x3 #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_value,
   input  logic        req_is_padding,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_result_pixel,
   output logic        rsp_changed,
   output logic        rsp_end_of_frame,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bm3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 5);

   function automatic logic [WW-1:0] clamp_w(input logic [10:0] v);
      if (v == 11'd0) begin
         return WW'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         return WW'(MAX_WIDTH);
      end
      return WW'(v);
   endfunction

   function automatic logic [HW-1:0] clamp_h(input logic [10:0] v);
      if (v == 11'd0) begin
         return HW'(1);
      end else if (32'(v) > MAX_HEIGHT) begin
         return HW'(MAX_HEIGHT);
      end
      return HW'(v);
   endfunction

   logic [1:0]    mode_ff;
   logic [8:0]    mask_ff;
   logic [10:0]   width_ff;
   logic [10:0]   height_ff;
   logic [WW-1:0] fr_w_ff;
   logic [HW-1:0] fr_h_ff;
   mode_type      fr_mode_ff;
   logic [8:0]    fr_mask_ff;
   logic [RW-1:0] in_row_ff;
   logic [AW-1:0] in_col_ff;
   logic [HW-1:0] orow_ff;
   logic [AW-1:0] ocol_ff;

   logic          csr_wr;
   logic          start;
   logic [WW-1:0] cur_w;
   logic [HW-1:0] cur_h;
   mode_type      cur_mode;
   logic [8:0]    cur_mask;
   logic          in_frame;
   logic          ignore;
   logic          take;
   logic          has_res;
   logic          in_last_col;
   logic          out_last_col;
   logic          eof;
   logic [HW:0]   orow_p1;
   logic [HW:0]   orow_p2;
   logic [WW:0]   ocol_p1;
   logic [WW:0]   ocol_p2;
   ctrl_type      ctrl_in;

   logic          va_ff;
   logic          vb_ff;
   logic          ov_ff;
   ctrl_type      actrl_ff;
   ctrl_type      bctrl_ff;
   logic          a_ready;
   logic          b_ready;
   logic          o_ready;
   logic          shift;
   column_type    a_col;
   window_type    win;
   logic [7:0]    k_pixel;
   logic          k_changed;
   logic [7:0]    res_pixel_ff;
   logic          res_changed_ff;
   logic          res_eof_ff;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 2'd2;
         mask_ff   <= 9'd511;
         width_ff  <= 11'd1024;
         height_ff <= 11'd1024;
      end else if (csr_wr) begin
         unique case (reg_type'(csr_paddr[3:2]))
            REG_MODE:   mode_ff   <= csr_pwdata[1:0];
            REG_MASK:   mask_ff   <= csr_pwdata[8:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[10:0];
            REG_HEIGHT: height_ff <= csr_pwdata[10:0];
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_type'(csr_paddr[3:2]))
         REG_MODE:   csr_prdata = {30'd0, mode_ff};
         REG_MASK:   csr_prdata = {23'd0, mask_ff};
         REG_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_HEIGHT: csr_prdata = {21'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign start    = (in_row_ff == '0) && (in_col_ff == '0);
   assign cur_w    = start ? clamp_w(width_ff) : fr_w_ff;
   assign cur_h    = start ? clamp_h(height_ff) : fr_h_ff;
   assign cur_mode = start ? mode_type'(mode_ff) : fr_mode_ff;
   assign cur_mask = start ? mask_ff : fr_mask_ff;
   assign in_frame = in_row_ff < RW'(cur_h);
   assign ignore   = req_is_padding && (start || in_frame);
   assign take     = req_valid && req_ready && !ignore;

   assign in_last_col  = in_col_ff == AW'(cur_w - WW'(1));
   assign out_last_col = ocol_ff == AW'(cur_w - WW'(1));
   assign has_res = (cur_w == WW'(1)) ? (in_row_ff >= RW'(4)) :
                    ((in_row_ff > RW'(2)) || (in_row_ff == RW'(2) && in_col_ff >= AW'(2)));
   assign eof = has_res && out_last_col && (orow_ff == HW'(cur_h - HW'(1)));

   assign orow_p1 = {1'b0, orow_ff} + (HW+1)'(1);
   assign orow_p2 = {1'b0, orow_ff} + (HW+1)'(2);
   assign ocol_p1 = (WW+1)'(ocol_ff) + (WW+1)'(1);
   assign ocol_p2 = (WW+1)'(ocol_ff) + (WW+1)'(2);

   always_comb begin
      ctrl_in.res  = has_res;
      ctrl_in.eof  = eof;
      ctrl_in.mode = cur_mode;
      ctrl_in.mask = cur_mask;
      ctrl_in.rv[0] = orow_ff >= HW'(2);
      ctrl_in.rv[1] = orow_ff >= HW'(1);
      ctrl_in.rv[2] = 1'b1;
      ctrl_in.rv[3] = orow_p1 < {1'b0, cur_h};
      ctrl_in.rv[4] = orow_p2 < {1'b0, cur_h};
      ctrl_in.cv[0] = ocol_ff >= AW'(2);
      ctrl_in.cv[1] = ocol_ff >= AW'(1);
      ctrl_in.cv[2] = 1'b1;
      ctrl_in.cv[3] = ocol_p1 < {1'b0, cur_w};
      ctrl_in.cv[4] = ocol_p2 < {1'b0, cur_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_w_ff    <= clamp_w(11'd1024);
         fr_h_ff    <= clamp_h(11'd1024);
         fr_mode_ff <= MODE_OPEN;
         fr_mask_ff <= 9'd511;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         orow_ff    <= '0;
         ocol_ff    <= '0;
      end else if (take) begin
         if (start) begin
            fr_w_ff    <= cur_w;
            fr_h_ff    <= cur_h;
            fr_mode_ff <= cur_mode;
            fr_mask_ff <= cur_mask;
         end
         if (eof) begin
            in_row_ff <= '0;
            in_col_ff <= '0;
            orow_ff   <= '0;
            ocol_ff   <= '0;
         end else begin
            if (in_last_col) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + RW'(1);
            end else begin
               in_col_ff <= in_col_ff + AW'(1);
            end
            if (has_res) begin
               if (out_last_col) begin
                  ocol_ff <= '0;
                  orow_ff <= orow_ff + HW'(1);
               end else begin
                  ocol_ff <= ocol_ff + AW'(1);
               end
            end
         end
      end
   end

   assign o_ready = !ov_ff || rsp_ready;
   assign b_ready = !vb_ff || o_ready;
   assign a_ready = !va_ff || b_ready;
   assign req_ready = a_ready;
   assign shift = va_ff && b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (take) begin
            va_ff <= 1'b1;
         end else if (b_ready) begin
            va_ff <= 1'b0;
         end
         if (b_ready) begin
            vb_ff <= va_ff && actrl_ff.res;
         end
         if (o_ready) begin
            ov_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         actrl_ff <= ctrl_in;
      end
      if (shift) begin
         bctrl_ff <= actrl_ff;
      end
      if (o_ready && vb_ff) begin
         res_pixel_ff   <= k_pixel;
         res_changed_ff <= k_changed;
         res_eof_ff     <= bctrl_ff.eof;
      end
   end

   bm3_linebuf #(
      .DEPTH(MAX_WIDTH),
      .AW(AW)
   ) u_linebuf (
      .clock(clock),
      .reset(reset),
      .load(take),
      .addr(in_col_ff),
      .pixel(req_pixel_value),
      .col(a_col)
   );

   for (genvar j = 0; j < WIN; j++) begin : g_cell
      if (j == 0) begin : g_head
         bm3_cell u_cell (
            .clock(clock),
            .shift(shift),
            .col_in(a_col),
            .col_out(win[j])
         );
      end else begin : g_body
         bm3_cell u_cell (
            .clock(clock),
            .shift(shift),
            .col_in(win[j-1]),
            .col_out(win[j])
         );
      end
   end

   bm3_kernel u_kernel (
      .win(win),
      .ctrl(bctrl_ff),
      .result_pixel(k_pixel),
      .changed(k_changed)
   );

   assign rsp_valid        = ov_ff;
   assign rsp_result_pixel = res_pixel_ff;
   assign rsp_changed      = res_changed_ff;
   assign rsp_end_of_frame = res_eof_ff;

endmodule
